>>> src/packet_encapsulate_and_segment_macros.svh
// Assertion macros for the packet framer.
// Both sample on clk and stay off while arst_n is low.
`ifndef PACKET_ENCAPSULATE_AND_SEGMENT_MACROS_SVH
`define PACKET_ENCAPSULATE_AND_SEGMENT_MACROS_SVH

// Same-cycle implication
`define PEF_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PEF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/pef_pkg.sv
package pef_pkg;

	localparam int unsigned PKT_HDR_BYTES = 16;
	localparam int unsigned FRM_HDR_BYTES = 12;
	localparam logic [15:0] MIN_FRAME = 16'd16;
	localparam logic [15:0] CFG_RESET = 16'd1400;
	localparam logic [4:0] PKT_IDX_PAYLOAD = 5'(PKT_HDR_BYTES);
	localparam logic [3:0] FHDR_IDX_LAST = 4'(FRM_HDR_BYTES - 1);

	// Result status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_LEN_ERR = 2'd1;
	localparam logic [1:0] ST_NO_PKT = 2'd2;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ERR    = 5'b00010,
		S_FSTART = 5'b00100,
		S_FHDR   = 5'b01000,
		S_PBYTE  = 5'b10000
	} state_t;

	typedef struct packed {
		logic accept;
		logic frame_start;
		logic emit_err;
		logic emit_fhdr;
		logic emit_pbyte;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic pkt_open;
		logic frame_empty;
		logic first;
		logic len_zero;
		logic hdr_done;
		logic frame_last;
		logic fhdr_last;
	} dp_status_t;

	// Big-endian byte pick from a 32-bit word
	function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = w[31:24];
			2'd1: b = w[23:16];
			2'd2: b = w[15:8];
			default: b = w[7:0];
		endcase
		return b;
	endfunction

endpackage

>>> src/pef_ctrl.sv
module pef_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pef_pkg::dp_status_t  sts,
	output pef_pkg::dp_cmd_t     cmd
);

	pef_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pef_pkg::S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign in_ready = (state_q == pef_pkg::S_IDLE);

	// Sequence one transaction: an error result, or packet bytes with a frame header before each new frame
	always_comb begin
		state_next = state_q;
		cmd = '0;
		unique case (state_q)
			pef_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.first) begin
						state_next = sts.len_zero ? pef_pkg::S_ERR : pef_pkg::S_FSTART;
					end else if (!sts.pkt_open) begin
						state_next = pef_pkg::S_ERR;
					end else if (sts.frame_empty) begin
						state_next = pef_pkg::S_FSTART;
					end else begin
						state_next = pef_pkg::S_PBYTE;
					end
				end
			end
			pef_pkg::S_ERR: begin
				if (sts.slot_free) begin
					cmd.emit_err = 1'b1;
					state_next = pef_pkg::S_IDLE;
				end
			end
			pef_pkg::S_FSTART: begin
				cmd.frame_start = 1'b1;
				state_next = pef_pkg::S_FHDR;
			end
			pef_pkg::S_FHDR: begin
				if (sts.slot_free) begin
					cmd.emit_fhdr = 1'b1;
					if (sts.fhdr_last) begin
						state_next = pef_pkg::S_PBYTE;
					end
				end
			end
			pef_pkg::S_PBYTE: begin
				if (sts.slot_free) begin
					cmd.emit_pbyte = 1'b1;
					if (sts.hdr_done) begin
						state_next = pef_pkg::S_IDLE;
					end else if (sts.frame_last) begin
						state_next = pef_pkg::S_FSTART;
					end
				end
			end
			default: begin
				state_next = pef_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> src/pef_dp.sv
module pef_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pef_pkg::dp_cmd_t     cmd,
	output pef_pkg::dp_status_t  sts,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  logic                 first_byte,
	input  logic [31:0]          packet_type,
	input  logic [31:0]          packet_id,
	input  logic [15:0]          payload_length,
	input  logic [7:0]           payload_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 end_of_frame,
	output logic                 end_of_packet,
	output logic                 last_of_run,
	output logic [1:0]           status
);

	// Control state
	logic [15:0] max_frame_q;
	logic        pkt_open_q;
	logic [16:0] pkt_left_q;
	logic [15:0] frame_left_q;
	logic [12:0] seq_q;
	logic        out_valid_q;

	// Captured item and counters
	logic [31:0] type_q;
	logic [31:0] id_q;
	logic [15:0] len_q;
	logic [7:0]  byte_q;
	logic [1:0]  err_q;
	logic [4:0]  pkt_idx_q;
	logic [3:0]  fh_idx_q;
	logic [15:0] frame_size_q;

	// Output register
	logic [7:0]  out_byte_q;
	logic        eof_q;
	logic        eop_q;
	logic        last_q;
	logic [1:0]  status_q;

	logic        slot_free;
	logic        emit;
	logic [15:0] lim;
	logic [15:0] size_next;
	logic [31:0] fh_word;
	logic [31:0] ph_word;
	logic [7:0]  pbyte;
	logic [16:0] pkt_total;

	assign slot_free = !out_valid_q || out_ready;
	assign emit = cmd.emit_err || cmd.emit_fhdr || cmd.emit_pbyte;

	// Frame size: clamp limit to the minimum, then take the smaller of limit and bytes left
	assign lim = (max_frame_q < pef_pkg::MIN_FRAME) ? pef_pkg::MIN_FRAME : max_frame_q;
	assign size_next = (pkt_left_q < {1'b0, lim}) ? pkt_left_q[15:0] : lim;

	assign pkt_total = 17'(pef_pkg::PKT_HDR_BYTES) + {1'b0, len_q};

	// Frame header words: sequence, size, size plus header
	always_comb begin
		case (fh_idx_q[3:2])
			2'd0: fh_word = {19'b0, seq_q};
			2'd1: fh_word = {16'b0, frame_size_q};
			default: fh_word = {15'b0, {1'b0, frame_size_q} + 17'(pef_pkg::FRM_HDR_BYTES)};
		endcase
	end

	// Packet header words: type, id, length, total
	always_comb begin
		case (pkt_idx_q[3:2])
			2'd0: ph_word = type_q;
			2'd1: ph_word = id_q;
			2'd2: ph_word = {16'b0, len_q};
			default: ph_word = {15'b0, pkt_total};
		endcase
	end

	assign pbyte = (pkt_idx_q == pef_pkg::PKT_IDX_PAYLOAD) ? byte_q
		: pef_pkg::word_byte(ph_word, pkt_idx_q[1:0]);

	assign sts.slot_free = slot_free;
	assign sts.pkt_open = pkt_open_q;
	assign sts.frame_empty = (frame_left_q == 16'd0);
	assign sts.first = first_byte;
	assign sts.len_zero = (payload_length == 16'd0);
	assign sts.hdr_done = (pkt_idx_q == pef_pkg::PKT_IDX_PAYLOAD);
	assign sts.frame_last = (frame_left_q == 16'd1);
	assign sts.fhdr_last = (fh_idx_q == pef_pkg::FHDR_IDX_LAST);

	// Configuration, packet and frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= pef_pkg::CFG_RESET;
			pkt_open_q <= 1'b0;
			pkt_left_q <= '0;
			frame_left_q <= '0;
			seq_q <= '0;
		end else begin
			if (cfg_we) begin
				max_frame_q <= cfg_wdata;
			end
			if (cmd.accept && first_byte) begin
				seq_q <= '0;
				frame_left_q <= '0;
				if (payload_length == 16'd0) begin
					pkt_open_q <= 1'b0;
					pkt_left_q <= '0;
				end else begin
					pkt_open_q <= 1'b1;
					pkt_left_q <= 17'(pef_pkg::PKT_HDR_BYTES) + {1'b0, payload_length};
				end
			end
			if (cmd.frame_start) begin
				seq_q <= seq_q + 13'd1;
				frame_left_q <= size_next;
			end
			if (cmd.emit_pbyte) begin
				pkt_left_q <= pkt_left_q - 17'd1;
				if (pkt_left_q == 17'd1) begin
					pkt_open_q <= 1'b0;
					frame_left_q <= '0;
				end else begin
					frame_left_q <= frame_left_q - 16'd1;
				end
			end
		end
	end

	// Capture the item and step the byte indexes
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= payload_byte;
			err_q <= first_byte ? pef_pkg::ST_LEN_ERR : pef_pkg::ST_NO_PKT;
			pkt_idx_q <= first_byte ? 5'd0 : pef_pkg::PKT_IDX_PAYLOAD;
			if (first_byte) begin
				type_q <= packet_type;
				id_q <= packet_id;
				len_q <= payload_length;
			end
		end
		if (cmd.frame_start) begin
			fh_idx_q <= '0;
			frame_size_q <= size_next;
		end
		if (cmd.emit_fhdr) begin
			fh_idx_q <= fh_idx_q + 4'd1;
		end
		if (cmd.emit_pbyte) begin
			pkt_idx_q <= pkt_idx_q + 5'd1;
		end
	end

	// Output register: load on emit, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			out_byte_q <= 8'd0;
			eof_q <= 1'b0;
			eop_q <= 1'b0;
			last_q <= 1'b1;
			status_q <= err_q;
		end else if (cmd.emit_fhdr) begin
			out_byte_q <= pef_pkg::word_byte(fh_word, fh_idx_q[1:0]);
			eof_q <= 1'b0;
			eop_q <= 1'b0;
			last_q <= 1'b0;
			status_q <= pef_pkg::ST_OK;
		end else if (cmd.emit_pbyte) begin
			out_byte_q <= pbyte;
			eof_q <= (frame_left_q == 16'd1);
			eop_q <= (pkt_left_q == 17'd1);
			last_q <= (pkt_idx_q == pef_pkg::PKT_IDX_PAYLOAD);
			status_q <= pef_pkg::ST_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign end_of_frame = eof_q;
	assign end_of_packet = eop_q;
	assign last_of_run = last_q;
	assign status = status_q;

endmodule

>>> src/packet_encapsulate_and_segment.sv
// The first result of a transaction is registered in S_ERR or S_PBYTE, or in S_FHDR
// after S_FSTART when a frame opens first. Results then leave one per cycle while
// out_ready is high, but S_FSTART sizes each frame ahead of its header. A first-byte
// transaction with a nonzero length gives 17 results plus 12 per frame header (at most
// 41). A new transaction is accepted the cycle after the last result is registered.
// Reset (arst_n low, asynchronous): no packet open, counters zero, frame limit 1400.
module packet_encapsulate_and_segment (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        first_byte,
	input  logic [31:0] packet_type,
	input  logic [31:0] packet_id,
	input  logic [15:0] payload_length,
	input  logic [7:0]  payload_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        end_of_frame,
	output logic        end_of_packet,
	output logic        last_of_run,
	output logic [1:0]  status
);

	`include "packet_encapsulate_and_segment_macros.svh"

	pef_pkg::dp_cmd_t    cmd;
	pef_pkg::dp_status_t sts;

	pef_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pef_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.first_byte     (first_byte),
		.packet_type    (packet_type),
		.packet_id      (packet_id),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.end_of_frame   (end_of_frame),
		.end_of_packet  (end_of_packet),
		.last_of_run    (last_of_run),
		.status         (status)
	);

	// Packet end always closes the transaction's run
	`PEF_ASSERT_IMPLY(a_eop_last, out_valid && end_of_packet, last_of_run && end_of_frame, "packet end not closing run")
	// Error results are single, zeroed and unmarked
	`PEF_ASSERT_IMPLY(a_err_result, out_valid && (status != pef_pkg::ST_OK), last_of_run && (out_byte == 8'd0) && !end_of_frame, "malformed error result")
	// One transaction at a time
	`PEF_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "input taken while busy")
	// No result is emitted in the cycle a transaction is taken
	`PEF_ASSERT_IMPLY(a_no_emit_idle, in_ready, !(cmd.emit_err || cmd.emit_fhdr || cmd.emit_pbyte), "emit while idle")

endmodule

>>> verif/packet_encapsulate_and_segment_tb.sv
`timescale 1ns / 1ps

module packet_encapsulate_and_segment_tb;

	import pef_pkg::*;

	localparam int unsigned SINK_HOLD = 300;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_ITEMS = 100;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_frame;
		logic       end_of_packet;
		logic       last_of_run;
		logic [1:0] status;
	} framed_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        first_byte;
	logic [31:0] packet_type;
	logic [31:0] packet_id;
	logic [15:0] payload_length;
	logic [7:0]  payload_byte;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_byte;
	logic        end_of_frame;
	logic        end_of_packet;
	logic        last_of_run;
	logic [1:0]  status;

	// Expected framed stream, oldest first
	framed_byte_t expected_stream[$];

	// Framer state as the predictor sees it
	logic        pkt_open;
	logic [16:0] pkt_bytes_left;
	logic [15:0] frm_bytes_left;
	logic [12:0] frm_sequence;
	logic [15:0] frame_limit;

	int unsigned fail_count;
	int unsigned items_sent;
	int unsigned quiet_cycles;
	bit          steady_flow;
	bit          sink_hold_req;

	packet_encapsulate_and_segment dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.first_byte    (first_byte),
		.packet_type   (packet_type),
		.packet_id     (packet_id),
		.payload_length(payload_length),
		.payload_byte  (payload_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.end_of_frame  (end_of_frame),
		.end_of_packet (end_of_packet),
		.last_of_run   (last_of_run),
		.status        (status)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	function automatic void push_result(input logic [7:0] data, input logic eof,
		input logic eop, input logic [1:0] st);
		framed_byte_t r;
		r.out_byte = data;
		r.end_of_frame = eof;
		r.end_of_packet = eop;
		r.last_of_run = 1'b0;
		r.status = st;
		expected_stream.push_back(r);
	endfunction

	function automatic void push_frame_word(input logic [31:0] w);
		push_result(w[31:24], 1'b0, 1'b0, ST_OK);
		push_result(w[23:16], 1'b0, 1'b0, ST_OK);
		push_result(w[15:8], 1'b0, 1'b0, ST_OK);
		push_result(w[7:0], 1'b0, 1'b0, ST_OK);
	endfunction

	// Predict one packet byte, opening a frame with its header when needed
	function automatic void frame_packet_byte(input logic [7:0] b);
		logic [15:0] lim;
		logic [16:0] size;
		if (!pkt_open)
			return;
		if (frm_bytes_left == 16'd0) begin
			lim = (frame_limit < MIN_FRAME) ? MIN_FRAME : frame_limit;
			size = (pkt_bytes_left < {1'b0, lim}) ? pkt_bytes_left : {1'b0, lim};
			frm_sequence = frm_sequence + 13'd1;
			frm_bytes_left = size[15:0];
			push_frame_word({19'd0, frm_sequence});
			push_frame_word({15'd0, size});
			push_frame_word({15'd0, size} + 32'(FRM_HDR_BYTES));
		end
		frm_bytes_left = frm_bytes_left - 16'd1;
		pkt_bytes_left = pkt_bytes_left - 17'd1;
		push_result(b, frm_bytes_left == 16'd0, pkt_bytes_left == 17'd0, ST_OK);
		if (pkt_bytes_left == 17'd0) begin
			pkt_open = 1'b0;
			frm_bytes_left = 16'd0;
		end
	endfunction

	function automatic void frame_packet_word(input logic [31:0] w);
		frame_packet_byte(w[31:24]);
		frame_packet_byte(w[23:16]);
		frame_packet_byte(w[15:8]);
		frame_packet_byte(w[7:0]);
	endfunction

	// Work out every result that one accepted transaction causes
	function automatic void frame_predict_step(input logic first, input logic [31:0] ptype,
		input logic [31:0] pid, input logic [15:0] len, input logic [7:0] data);
		int unsigned before_n;
		before_n = expected_stream.size();
		if (first) begin
			pkt_open = 1'b0;
			pkt_bytes_left = 17'd0;
			frm_bytes_left = 16'd0;
			frm_sequence = 13'd0;
			if (len == 16'd0) begin
				push_result(8'd0, 1'b0, 1'b0, ST_LEN_ERR);
			end else begin
				pkt_open = 1'b1;
				pkt_bytes_left = 17'(PKT_HDR_BYTES) + {1'b0, len};
				frame_packet_word(ptype);
				frame_packet_word(pid);
				frame_packet_word({16'd0, len});
				frame_packet_word(32'(PKT_HDR_BYTES) + {16'd0, len});
				frame_packet_byte(data);
			end
		end else if (!pkt_open) begin
			push_result(8'd0, 1'b0, 1'b0, ST_NO_PKT);
		end else begin
			frame_packet_byte(data);
		end
		if (expected_stream.size() > before_n)
			expected_stream[expected_stream.size() - 1].last_of_run = 1'b1;
	endfunction

	// ---------------------------------------------------------------- driving

	function automatic int unsigned idle_draw();
		return steady_flow ? 0 : $urandom_range(15, 0);
	endfunction

	// Offer one transaction and predict its results once accepted
	task automatic send_item(input logic first, input logic [31:0] ptype,
		input logic [31:0] pid, input logic [15:0] len, input logic [7:0] data);
		int unsigned gap;
		gap = idle_draw();
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		first_byte <= first;
		packet_type <= ptype;
		packet_id <= pid;
		payload_length <= len;
		payload_byte <= data;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		frame_predict_step(first, ptype, pid, len, data);
		items_sent++;
	endtask

	// Continuation bytes carry random header fields that the block must ignore
	task automatic send_followers(input int unsigned count);
		repeat (count)
			send_item(1'b0, $urandom, $urandom, 16'($urandom), 8'($urandom));
	endtask

	// Open a packet and send the first count bytes of it
	task automatic send_packet(input logic [15:0] len, input int unsigned count);
		send_item(1'b1, $urandom, $urandom, len, 8'($urandom));
		if (count > 1)
			send_followers(count - 1);
	endtask

	// Hold the input until every expected result has arrived
	task automatic wait_for_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_stream.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_frame_limit(input logic [15:0] value);
		wait_for_drain();
		repeat (4) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		frame_limit = value;
	endtask

	function automatic logic [15:0] pick_frame_limit();
		case ($urandom_range(4, 0))
			0: return MIN_FRAME;
			1: return 16'($urandom_range(15, 0));
			2: return 16'($urandom_range(64, 17));
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_directed();
		// stray byte before any packet, then a zero-length packet
		send_item(1'b0, '1, '1, '1, 8'hFF);
		send_item(1'b1, '1, '1, 16'd0, 8'h00);
		// single-byte packet with all-ones header, then a stray byte after it
		send_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 8'hFF);
		send_item(1'b0, 32'd0, 32'd0, 16'd0, 8'h00);
		// all-zero header, three bytes
		send_item(1'b1, 32'd0, 32'd0, 16'd3, 8'h00);
		send_item(1'b0, 32'd0, 32'd0, 16'd0, 8'h80);
		send_item(1'b0, 32'd0, 32'd0, 16'd0, 8'h01);
		// longest packet, abandoned by a new packet that completes
		send_item(1'b1, 32'h8000_0001, 32'h7FFF_FFFE, 16'hFFFF, 8'hA5);
		send_item(1'b0, 32'd0, 32'd0, 16'd0, 8'h5A);
		send_item(1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 16'd2, 8'h11);
		send_item(1'b0, 32'd0, 32'd0, 16'd0, 8'h22);
		// zero length drops an open packet
		send_item(1'b1, 32'hCAFE_0001, 32'h0000_0042, 16'd10, 8'h33);
		send_item(1'b1, 32'hCAFE_0002, 32'h0000_0043, 16'd0, 8'h44);
		send_item(1'b0, 32'd0, 32'd0, 16'd0, 8'h55);
	endtask

	task automatic test_frame_limits();
		// smallest legal limit: one full frame then a short one
		write_frame_limit(MIN_FRAME);
		send_packet(16'd4, 4);
		// limits below the minimum act as the minimum
		write_frame_limit(16'd0);
		send_packet(16'd1, 1);
		write_frame_limit(16'd15);
		send_packet(16'd2, 2);
		// change the limit while a packet is open; the next frame picks it up
		write_frame_limit(16'd20);
		send_packet(16'd30, 1);
		write_frame_limit(MIN_FRAME);
		send_followers(29);
		// largest limit: whole packet in one frame
		write_frame_limit(16'hFFFF);
		send_packet(16'd3, 3);
	endtask

	task automatic test_random_traffic();
		int unsigned stop_at;
		int unsigned len;
		int unsigned count;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(7, 0) == 0)
				write_frame_limit(pick_frame_limit());
			steady_flow = ($urandom_range(4, 0) == 0);
			case ($urandom_range(9, 0))
				0: send_followers(1);
				1: send_item(1'b1, $urandom, $urandom, 16'd0, 8'($urandom));
				2: begin
					// long packet, usually cut short by whatever comes next
					len = $urandom_range(65535, 1);
					count = $urandom_range(20, 1);
					send_packet(16'(len), (count > len) ? len : count);
				end
				3: begin
					// pause mid-packet until the block has emptied
					len = $urandom_range(40, 2);
					count = $urandom_range(len - 1, 1);
					send_packet(16'(len), count);
					wait_for_drain();
					send_followers(len - count);
				end
				default: begin
					len = $urandom_range(48, 1);
					send_packet(16'(len), len);
				end
			endcase
		end
		steady_flow = 1'b0;
	endtask

	// Receiver holds off while the sender keeps offering bytes
	task automatic test_output_backpressure();
		write_frame_limit(MIN_FRAME);
		steady_flow = 1'b1;
		sink_hold_req = 1'b1;
		send_packet(16'd40, 40);
		steady_flow = 1'b0;
	endtask

	// ---------------------------------------------------------------- receiver

	initial begin : result_sink
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				out_ready <= 1'b0;
				repeat (SINK_HOLD) @(negedge clk);
				sink_hold_req = 1'b0;
			end else begin
				stall = idle_draw();
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : result_check
		framed_byte_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_stream.size() == 0) begin
				$error("unexpected result: out_byte %02h status %0d", out_byte, status);
				fail_count++;
			end else begin
				want = expected_stream.pop_front();
				if (out_byte !== want.out_byte) begin
					$error("out_byte: expected %02h, got %02h", want.out_byte, out_byte);
					fail_count++;
				end
				if (end_of_frame !== want.end_of_frame) begin
					$error("end_of_frame: expected %0b, got %0b", want.end_of_frame,
						end_of_frame);
					fail_count++;
				end
				if (end_of_packet !== want.end_of_packet) begin
					$error("end_of_packet: expected %0b, got %0b", want.end_of_packet,
						end_of_packet);
					fail_count++;
				end
				if (last_of_run !== want.last_of_run) begin
					$error("last_of_run: expected %0b, got %0b", want.last_of_run,
						last_of_run);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
	end

	// Abort when no transaction moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 16'd0;
		in_valid = 1'b0;
		first_byte = 1'b0;
		packet_type = 32'd0;
		packet_id = 32'd0;
		payload_length = 16'd0;
		payload_byte = 8'd0;
		out_ready = 1'b0;
		fail_count = 0;
		items_sent = 0;
		quiet_cycles = 0;
		steady_flow = 1'b0;
		sink_hold_req = 1'b0;
		pkt_open = 1'b0;
		pkt_bytes_left = 17'd0;
		frm_bytes_left = 16'd0;
		frm_sequence = 13'd0;
		frame_limit = CFG_RESET;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_frame_limits();
		test_random_traffic();
		test_output_backpressure();

		// let the last results out, then look for anything left over
		wait_for_drain();
		repeat (20) @(posedge clk);
		if (expected_stream.size() != 0) begin
			$error("%0d expected results never arrived", expected_stream.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
